### rtl/bfsp_pkg.sv
package bfsp_pkg;

  // Graph size and field widths
  localparam int MAX_VERTICES = 16;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int EDGE_AW      = 2 * VIDX_W;
  localparam int EDGE_DEPTH   = MAX_VERTICES * MAX_VERTICES;
  localparam int VCNT_W       = 5;
  localparam int INF_W        = 23;
  localparam int WEIGHT_W     = 16;
  localparam int DIST_W       = 24;

  localparam logic [INF_W-1:0]  RESET_INF    = INF_W'(999);
  localparam logic [VCNT_W-1:0] RESET_VCOUNT = VCNT_W'(MAX_VERTICES);

  localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

  // Operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Configuration register indexes
  localparam logic CFG_VCOUNT = 1'b0;
  localparam logic CFG_INF    = 1'b1;

  typedef struct packed {
    logic                       op;
    logic [VIDX_W-1:0]          from_vertex;
    logic [VIDX_W-1:0]          to_vertex;
    logic signed [WEIGHT_W-1:0] edge_weight_in;
    logic                       has_edge;
    logic [VIDX_W-1:0]          source;
  } in_word_t;

  typedef struct packed {
    logic [VIDX_W-1:0]        vertex_index;
    logic signed [DIST_W-1:0] distance;
    logic                     reached;
    logic                     last;
  } out_word_t;

  // Edge store write and read bundles
  typedef struct packed {
    logic                       en;
    logic [EDGE_AW-1:0]         addr;
    logic signed [WEIGHT_W-1:0] weight;
    logic                       present;
  } edge_wr_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight;
    logic                       present;
  } edge_rd_t;

endpackage

### rtl/bellman_ford_shortest_paths.sv
// Bellman-Ford single-source shortest paths over a 16-vertex adjacency
// matrix. A load word (op = 0) writes one edge. A start word
// (op = 1) sets all distances to the infinity register and the source, if
// below n, to zero, runs n-1 rounds over all vertices and then returns n
// result words, one per vertex in order, with last set on the final one.
// A start word initialises the table, then each round reads the distance
// of every vertex in turn and relaxes the row of each reached one, fed
// with one edge a cycle from the edge store through the single
// add/clamp/compare unit. The input stalls throughout a run. Vertex counts
// of zero are taken as one and counts above 16 as 16; no negative-cycle
// check is made.
module bellman_ford_shortest_paths (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  bfsp_pkg::in_word_t           in_word,
  output logic                         out_valid,
  input  logic                         out_stall,
  output bfsp_pkg::out_word_t          out_word,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_index,
  input  logic [bfsp_pkg::INF_W-1:0]   cfg_wdata
);
  import bfsp_pkg::*;

  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_ROWSTART = 2'd1;
  localparam logic [1:0] ST_RELAX    = 2'd2;
  localparam logic [1:0] ST_OUT      = 2'd3;

  logic [1:0]               st_r, st_nxt;
  logic [VCNT_W-1:0]        vc_r;
  logic [INF_W-1:0]         inf_r;
  logic [VIDX_W-1:0]        nl_r, nl_nxt;
  logic [VIDX_W-1:0]        u_r, u_nxt;
  logic [VIDX_W-1:0]        j_r, j_nxt;
  logic [VIDX_W-1:0]        round_r, round_nxt;
  logic signed [DIST_W-1:0] du_r, du_nxt;
  logic signed [DIST_W-1:0] d_r [MAX_VERTICES];
  logic                     out_valid_r, out_valid_nxt;
  out_word_t                out_word_r, out_word_nxt;

  logic                     in_acc;
  logic                     start_acc;
  logic [VCNT_W-1:0]        n_sat;
  logic [VIDX_W-1:0]        rd_idx;
  logic signed [DIST_W-1:0] dist_rd;
  logic                     rd_reached;
  logic                     du_reached;
  logic signed [DIST_W:0]   sum;
  logic signed [DIST_W-1:0] cand;
  logic                     upd;
  logic                     out_free;
  logic [VIDX_W-1:0]        jn;
  edge_wr_t                 ewr;
  edge_rd_t                 erd;

  assign in_stall  = (st_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign start_acc = in_acc && (in_word.op == OP_START);

  // Saturated vertex count
  always_comb begin
    if (vc_r == '0) begin
      n_sat = VCNT_W'(1);
    end else if (vc_r > VCNT_W'(MAX_VERTICES)) begin
      n_sat = VCNT_W'(MAX_VERTICES);
    end else begin
      n_sat = vc_r;
    end
  end

  // Edge store
  assign ewr.en      = in_acc && (in_word.op == OP_LOAD);
  assign ewr.addr    = {in_word.from_vertex, in_word.to_vertex};
  assign ewr.weight  = in_word.edge_weight_in;
  assign ewr.present = in_word.has_edge;

  // Prefetch the next edge of the row
  assign jn = (st_r == ST_RELAX) ? j_r + VIDX_W'(1) : '0;

  bfsp_edge_mem u_edge_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (ewr),
    .rd_addr ({u_r, jn}),
    .rd      (erd)
  );

  // Single distance read port
  assign rd_idx     = (st_r == ST_ROWSTART) ? u_r : j_r;
  assign dist_rd    = d_r[rd_idx];
  assign rd_reached = $signed({dist_rd[DIST_W-1], dist_rd}) < $signed({2'b00, inf_r});
  assign du_reached = $signed({du_r[DIST_W-1], du_r}) < $signed({2'b00, inf_r});

  // Shared add, clamp and compare unit
  assign sum = $signed({du_r[DIST_W-1], du_r})
             + $signed({{(DIST_W+1-WEIGHT_W){erd.weight[WEIGHT_W-1]}}, erd.weight});

  always_comb begin
    if (sum[DIST_W] != sum[DIST_W-1]) begin
      cand = sum[DIST_W] ? DIST_MIN : DIST_MAX;
    end else begin
      cand = sum[DIST_W-1:0];
    end
  end

  assign upd      = (st_r == ST_RELAX) && erd.present && (cand < dist_rd);
  assign out_free = !out_valid_r || !out_stall;

  // Sequencer
  always_comb begin
    st_nxt        = st_r;
    nl_nxt        = nl_r;
    u_nxt         = u_r;
    j_nxt         = j_r;
    round_nxt     = round_r;
    du_nxt        = du_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (st_r)
      ST_IDLE: begin
        if (start_acc) begin
          nl_nxt    = VIDX_W'(n_sat - VCNT_W'(1));
          u_nxt     = '0;
          j_nxt     = '0;
          round_nxt = VIDX_W'(1);
          st_nxt    = (n_sat == VCNT_W'(1)) ? ST_OUT : ST_ROWSTART;
        end
      end

      ST_ROWSTART: begin
        du_nxt = dist_rd;
        j_nxt  = '0;
        if (rd_reached) begin
          st_nxt = ST_RELAX;
        end else if (u_r == nl_r) begin
          u_nxt = '0;
          if (round_r == nl_r) begin
            st_nxt = ST_OUT;
          end else begin
            round_nxt = round_r + VIDX_W'(1);
          end
        end else begin
          u_nxt = u_r + VIDX_W'(1);
        end
      end

      ST_RELAX: begin
        // a self-loop update changes the row's own distance
        if (upd && (j_r == u_r)) begin
          du_nxt = cand;
        end
        if (j_r == nl_r) begin
          j_nxt  = '0;
          st_nxt = ST_ROWSTART;
          if (u_r == nl_r) begin
            u_nxt = '0;
            if (round_r == nl_r) begin
              st_nxt = ST_OUT;
            end else begin
              round_nxt = round_r + VIDX_W'(1);
            end
          end else begin
            u_nxt = u_r + VIDX_W'(1);
          end
        end else begin
          j_nxt = j_r + VIDX_W'(1);
        end
      end

      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_word_nxt.vertex_index = j_r;
          out_word_nxt.distance     = dist_rd;
          out_word_nxt.reached      = rd_reached;
          out_word_nxt.last         = (j_r == nl_r);
          if (j_r == nl_r) begin
            j_nxt  = '0;
            st_nxt = ST_IDLE;
          end else begin
            j_nxt = j_r + VIDX_W'(1);
          end
        end
      end

      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      vc_r        <= RESET_VCOUNT;
      inf_r       <= RESET_INF;
      nl_r        <= '0;
      u_r         <= '0;
      j_r         <= '0;
      round_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      nl_r        <= nl_nxt;
      u_r         <= u_nxt;
      j_r         <= j_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_VCOUNT: vc_r  <= cfg_wdata[VCNT_W-1:0];
          CFG_INF:    inf_r <= cfg_wdata;
          default:    ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    du_r       <= du_nxt;
    out_word_r <= out_word_nxt;
  end

  // Distance table: set to infinity on start (source to zero), lowered by relaxation
  always_ff @(posedge clk) begin
    if (start_acc) begin
      for (int v = 0; v < MAX_VERTICES; v++) begin
        if ((VIDX_W'(v) == in_word.source) && ({1'b0, in_word.source} < n_sat)) begin
          d_r[v] <= '0;
        end else begin
          d_r[v] <= $signed({1'b0, inf_r});
        end
      end
    end else if (upd) begin
      d_r[j_r] <= cand;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTHESIS
  // row index never runs past the last vertex in use
  a_relax_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RELAX) |-> (j_r <= nl_r && u_r <= nl_r))
    else $error("relaxation index beyond vertex range");

  // rounds stay within one to n-1
  a_round: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_ROWSTART) |-> (round_r != '0 && round_r <= nl_r))
    else $error("round counter out of range");

  // a distance being relaxed never exceeds infinity
  a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RELAX) |-> ($signed({dist_rd[DIST_W-1], dist_rd}) <= $signed({2'b00, inf_r})))
    else $error("stored distance above infinity");

  // a row is only relaxed from a reached vertex
  a_row_reached: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RELAX && $past(st_r) == ST_ROWSTART) |-> du_reached)
    else $error("relaxation from unreached vertex");
`endif

endmodule

### rtl/bfsp_edge_mem.sv
module bfsp_edge_mem (
  input  logic               clk,
  input  logic               rst_n,
  input  bfsp_pkg::edge_wr_t wr,
  input  logic [bfsp_pkg::EDGE_AW-1:0] rd_addr,
  output bfsp_pkg::edge_rd_t rd
);
  import bfsp_pkg::*;

  logic signed [WEIGHT_W-1:0] weight_mem [EDGE_DEPTH];
  logic [EDGE_DEPTH-1:0]      present_r;
  logic signed [WEIGHT_W-1:0] weight_q_r;
  logic                       present_q_r;

  // Weight store: one write, one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr.en) begin
      weight_mem[wr.addr] <= wr.weight;
    end
    weight_q_r <= weight_mem[rd_addr];
  end

  // Presence flags, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r   <= '0;
      present_q_r <= 1'b0;
    end else begin
      if (wr.en) begin
        present_r[wr.addr] <= wr.present;
      end
      present_q_r <= present_r[rd_addr];
    end
  end

  assign rd.weight  = weight_q_r;
  assign rd.present = present_q_r;

endmodule
